@@ rtl/hdt_pkg.sv @@
// Shared types, sizes and codes of the header dynamic table.
`default_nettype none
package hdt_pkg;

  localparam int ENTRIES     = 16;
  localparam int NAME_BYTES  = 48;
  localparam int VALUE_BYTES = 128;
  localparam int INDEX_BASE  = 62;

  // One lane per slot plus a spare lane that collects the open stream.
  localparam int LANES    = ENTRIES + 1;
  localparam int LANE_W   = $clog2(LANES);
  localparam int SLOT_W   = $clog2(ENTRIES);
  localparam int OCC_W    = $clog2(ENTRIES + 1);
  localparam int NAME_AW  = $clog2(NAME_BYTES);
  localparam int VALUE_AW = $clog2(VALUE_BYTES);
  localparam int NCNT_W   = $clog2(NAME_BYTES + 2);
  localparam int VCNT_W   = $clog2(VALUE_BYTES + 2);

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_READ   = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_ABSORBED = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REJECTED = 3'd2,
    ST_FOUND    = 3'd3,
    ST_MISS     = 3'd4,
    ST_READ_OK  = 3'd5,
    ST_BAD_IDX  = 3'd6,
    ST_CLEARED  = 3'd7
  } status_e;

  typedef struct packed {
    req_type_e   req_type;
    logic        part;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last;
    logic [6:0]  entry_index;
    logic [6:0]  byte_offset;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [6:0]  found_index;
    logic [7:0]  read_byte;
    logic [5:0]  name_length;
    logic [7:0]  value_length;
    logic [4:0]  entry_count;
  } rsp_t;

  // Command from the control logic to the slot directory.
  typedef struct packed {
    logic              insert;
    logic              clear;
    logic [NCNT_W-1:0] nlen;
    logic [VCNT_W-1:0] vlen;
  } dir_cmd_t;

  // Slot lookup result for a read.
  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic [NCNT_W-1:0] nlen;
    logic [VCNT_W-1:0] vlen;
  } dir_rd_t;

endpackage
`default_nettype wire

@@ rtl/hdt_if.sv @@
// Valid/ready channel interfaces for request and response words.
`default_nettype none
interface hdt_req_if;
  logic          valid;
  logic          ready;
  hdt_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface hdt_rsp_if;
  logic          valid;
  logic          ready;
  hdt_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/hdt_lane_ram.sv @@
// Byte-lane memory: one word per byte offset, one byte lane per table lane.
`default_nettype none
module hdt_lane_ram #(
  parameter int DEPTH  = 48,
  parameter int AW     = 6,
  parameter int LANES  = 17,
  parameter int LANE_W = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  we_i,
  input  wire logic [AW-1:0]         waddr_i,
  input  wire logic [LANE_W-1:0]     wlane_i,
  input  wire logic [7:0]            wdata_i,
  input  wire logic                  re_i,
  input  wire logic [AW-1:0]         raddr_i,
  output logic      [LANES*8-1:0]    rdata_o
);

  logic [LANES*8-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i][wlane_i*8 +: 8] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/hdt_slot_dir.sv @@
// Slot directory: slot-to-lane map, entry lengths, occupancy and match select.
`default_nettype none
module hdt_slot_dir (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire hdt_pkg::dir_cmd_t                 cmd_i,
  input  wire logic [hdt_pkg::LANES-1:0]         flags_i,
  input  wire logic [hdt_pkg::SLOT_W-1:0]        rd_slot_i,
  output hdt_pkg::dir_rd_t                       rd_o,
  output logic [hdt_pkg::LANE_W-1:0]             spare_o,
  output logic [hdt_pkg::OCC_W-1:0]              occ_o,
  output logic [hdt_pkg::OCC_W-1:0]              occ_next_o,
  output logic                                   hit_o,
  output logic [hdt_pkg::SLOT_W-1:0]             hit_slot_o
);

  logic [hdt_pkg::LANE_W-1:0] lane_q [hdt_pkg::ENTRIES];
  logic [hdt_pkg::NCNT_W-1:0] nlen_q [hdt_pkg::ENTRIES];
  logic [hdt_pkg::VCNT_W-1:0] vlen_q [hdt_pkg::ENTRIES];
  logic [hdt_pkg::LANE_W-1:0] spare_q;
  logic [hdt_pkg::OCC_W-1:0]  occ_q, occ_d;
  logic [hdt_pkg::ENTRIES-1:0] match;

  always_comb begin
    occ_d = occ_q;
    if (cmd_i.clear) begin
      occ_d = '0;
    end else if (cmd_i.insert && (occ_q < hdt_pkg::OCC_W'(hdt_pkg::ENTRIES))) begin
      occ_d = occ_q + 1'b1;
    end
  end

  // Insert moves the spare lane to slot 0; the lane of the last slot becomes spare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hdt_pkg::ENTRIES; i++) begin
        lane_q[i] <= hdt_pkg::LANE_W'(i);
      end
      spare_q <= hdt_pkg::LANE_W'(hdt_pkg::ENTRIES);
      occ_q   <= '0;
    end else begin
      occ_q <= occ_d;
      if (cmd_i.insert) begin
        lane_q[0] <= spare_q;
        for (int i = 1; i < hdt_pkg::ENTRIES; i++) begin
          lane_q[i] <= lane_q[i-1];
        end
        spare_q <= lane_q[hdt_pkg::ENTRIES-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      nlen_q[0] <= cmd_i.nlen;
      vlen_q[0] <= cmd_i.vlen;
      for (int i = 1; i < hdt_pkg::ENTRIES; i++) begin
        nlen_q[i] <= nlen_q[i-1];
        vlen_q[i] <= vlen_q[i-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < hdt_pkg::ENTRIES; i++) begin
      match[i] = (hdt_pkg::OCC_W'(i) < occ_q) && flags_i[lane_q[i]] &&
                 (nlen_q[i] == cmd_i.nlen) && (vlen_q[i] == cmd_i.vlen);
    end
  end

  // Newest entry wins: lowest slot number.
  always_comb begin
    hit_o      = 1'b0;
    hit_slot_o = '0;
    for (int i = hdt_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_o      = 1'b1;
        hit_slot_o = hdt_pkg::SLOT_W'(i);
      end
    end
  end

  assign rd_o.lane  = lane_q[rd_slot_i];
  assign rd_o.nlen  = nlen_q[rd_slot_i];
  assign rd_o.vlen  = vlen_q[rd_slot_i];
  assign spare_o    = spare_q;
  assign occ_o      = occ_q;
  assign occ_next_o = occ_d;

endmodule
`default_nettype wire

@@ rtl/header_dynamic_table_top.sv @@
// Top level of the header dynamic table: control, stream counters and lane memories.
`default_nettype none
// A request word first issues, at acceptance, a read of one word of both the name and
// value memories, whose 17 byte lanes hold the same byte offset of every stored entry
// plus the open stream; once any earlier response is taken, it compares the new byte
// against all lanes at once, writes it into the spare lane and registers the response.
// A new word is taken while a finished response still waits. Inserts need no copy:
// the spare lane simply becomes slot 0. Clear and find close in one step.
module header_dynamic_table_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hdt_req_if.sink    req_i,
  hdt_rsp_if.source  rsp_o
);

  logic                        busy_q;
  logic                        fire, done;
  hdt_pkg::req_t               req_q;
  logic [hdt_pkg::NCNT_W-1:0]  ncnt_q, ncnt_d, ncnt_new;
  logic [hdt_pkg::VCNT_W-1:0]  vcnt_q, vcnt_d, vcnt_new;
  logic [hdt_pkg::LANES-1:0]   flags_q, flags_d, flags_new;
  logic                        out_valid_q;
  hdt_pkg::rsp_t               rsp_q, rsp_d;

  logic [hdt_pkg::NAME_AW-1:0]  name_raddr;
  logic [hdt_pkg::VALUE_AW-1:0] value_raddr;
  logic [hdt_pkg::LANES*8-1:0]  name_rdata, value_rdata;
  logic                         name_we, value_we;

  logic is_stream, take_n, take_v, store_n, store_v, close, fits;
  logic is_clear, is_read, rd_ok;
  logic [6:0] rd_diff;

  hdt_pkg::dir_cmd_t           cmd;
  hdt_pkg::dir_rd_t            dir_rd;
  logic [hdt_pkg::LANE_W-1:0]  spare;
  logic [hdt_pkg::OCC_W-1:0]   occ, occ_next;
  logic                        hit;
  logic [hdt_pkg::SLOT_W-1:0]  hit_slot;
  logic [7:0]                  lane_byte;

  assign req_i.ready = !busy_q;
  assign fire        = req_i.valid && !busy_q;
  assign done        = busy_q && (!out_valid_q || rsp_o.ready);

  assign name_raddr  = (req_i.payload.req_type == hdt_pkg::REQ_READ) ?
                       hdt_pkg::NAME_AW'(req_i.payload.byte_offset) :
                       hdt_pkg::NAME_AW'(ncnt_q);
  assign value_raddr = (req_i.payload.req_type == hdt_pkg::REQ_READ) ?
                       hdt_pkg::VALUE_AW'(req_i.payload.byte_offset) :
                       hdt_pkg::VALUE_AW'(vcnt_q);

  hdt_lane_ram #(
    .DEPTH  (hdt_pkg::NAME_BYTES),
    .AW     (hdt_pkg::NAME_AW),
    .LANES  (hdt_pkg::LANES),
    .LANE_W (hdt_pkg::LANE_W)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (hdt_pkg::NAME_AW'(ncnt_q)),
    .wlane_i (spare),
    .wdata_i (req_q.data_byte),
    .re_i    (fire),
    .raddr_i (name_raddr),
    .rdata_o (name_rdata)
  );

  hdt_lane_ram #(
    .DEPTH  (hdt_pkg::VALUE_BYTES),
    .AW     (hdt_pkg::VALUE_AW),
    .LANES  (hdt_pkg::LANES),
    .LANE_W (hdt_pkg::LANE_W)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (value_we),
    .waddr_i (hdt_pkg::VALUE_AW'(vcnt_q)),
    .wlane_i (spare),
    .wdata_i (req_q.data_byte),
    .re_i    (fire),
    .raddr_i (value_raddr),
    .rdata_o (value_rdata)
  );

  assign is_clear  = (req_q.req_type == hdt_pkg::REQ_CLEAR);
  assign is_read   = (req_q.req_type == hdt_pkg::REQ_READ);
  assign is_stream = (req_q.req_type == hdt_pkg::REQ_INSERT) ||
                     (req_q.req_type == hdt_pkg::REQ_FIND);
  assign take_n    = is_stream && req_q.has_byte && !req_q.part;
  assign take_v    = is_stream && req_q.has_byte && req_q.part;
  assign store_n   = take_n && (ncnt_q < hdt_pkg::NCNT_W'(hdt_pkg::NAME_BYTES));
  assign store_v   = take_v && (vcnt_q < hdt_pkg::VCNT_W'(hdt_pkg::VALUE_BYTES));
  assign name_we   = done && store_n;
  assign value_we  = done && store_v;
  assign close     = is_stream && req_q.last;

  // Counters saturate one past the limit so an over-long stream stays visible.
  assign ncnt_new = ncnt_q +
    hdt_pkg::NCNT_W'(take_n && (ncnt_q <= hdt_pkg::NCNT_W'(hdt_pkg::NAME_BYTES)));
  assign vcnt_new = vcnt_q +
    hdt_pkg::VCNT_W'(take_v && (vcnt_q <= hdt_pkg::VCNT_W'(hdt_pkg::VALUE_BYTES)));

  assign fits = (ncnt_new != '0) &&
                (ncnt_new <= hdt_pkg::NCNT_W'(hdt_pkg::NAME_BYTES)) &&
                (vcnt_new <= hdt_pkg::VCNT_W'(hdt_pkg::VALUE_BYTES));

  always_comb begin
    for (int l = 0; l < hdt_pkg::LANES; l++) begin
      flags_new[l] = flags_q[l];
      if (store_n && (name_rdata[l*8 +: 8] != req_q.data_byte)) begin
        flags_new[l] = 1'b0;
      end
      if (store_v && (value_rdata[l*8 +: 8] != req_q.data_byte)) begin
        flags_new[l] = 1'b0;
      end
    end
  end

  assign cmd.insert = done && close && (req_q.req_type == hdt_pkg::REQ_INSERT) && fits;
  assign cmd.clear  = done && is_clear;
  assign cmd.nlen   = ncnt_new;
  assign cmd.vlen   = vcnt_new;

  assign rd_diff = req_q.entry_index - 7'(hdt_pkg::INDEX_BASE);
  assign rd_ok   = (req_q.entry_index >= 7'(hdt_pkg::INDEX_BASE)) && (rd_diff < 7'(occ));

  hdt_slot_dir u_dir (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .flags_i    (flags_new),
    .rd_slot_i  (rd_diff[hdt_pkg::SLOT_W-1:0]),
    .rd_o       (dir_rd),
    .spare_o    (spare),
    .occ_o      (occ),
    .occ_next_o (occ_next),
    .hit_o      (hit),
    .hit_slot_o (hit_slot)
  );

  always_comb begin
    lane_byte = 8'd0;
    if (!req_q.part) begin
      if (hdt_pkg::NCNT_W'(req_q.byte_offset) < dir_rd.nlen &&
          req_q.byte_offset < 7'(hdt_pkg::NAME_BYTES)) begin
        lane_byte = name_rdata[dir_rd.lane*8 +: 8];
      end
    end else begin
      if (hdt_pkg::VCNT_W'(req_q.byte_offset) < dir_rd.vlen) begin
        lane_byte = value_rdata[dir_rd.lane*8 +: 8];
      end
    end
  end

  always_comb begin
    rsp_d              = '0;
    rsp_d.status       = hdt_pkg::ST_ABSORBED;
    rsp_d.entry_count  = 5'(occ_next);
    unique case (req_q.req_type)
      hdt_pkg::REQ_CLEAR: begin
        rsp_d.status = hdt_pkg::ST_CLEARED;
      end
      hdt_pkg::REQ_READ: begin
        if (rd_ok) begin
          rsp_d.status       = hdt_pkg::ST_READ_OK;
          rsp_d.read_byte    = lane_byte;
          rsp_d.name_length  = 6'(dir_rd.nlen);
          rsp_d.value_length = 8'(dir_rd.vlen);
        end else begin
          rsp_d.status = hdt_pkg::ST_BAD_IDX;
        end
      end
      hdt_pkg::REQ_INSERT: begin
        if (req_q.last) begin
          rsp_d.status = fits ? hdt_pkg::ST_INSERTED : hdt_pkg::ST_REJECTED;
        end
      end
      hdt_pkg::REQ_FIND: begin
        if (req_q.last) begin
          if (fits && hit) begin
            rsp_d.status      = hdt_pkg::ST_FOUND;
            rsp_d.found_index = 7'(hdt_pkg::INDEX_BASE) + 7'(hit_slot);
          end else begin
            rsp_d.status = hdt_pkg::ST_MISS;
          end
        end
      end
      default: begin
        rsp_d.status = hdt_pkg::ST_ABSORBED;
      end
    endcase
  end

  always_comb begin
    ncnt_d  = ncnt_q;
    vcnt_d  = vcnt_q;
    flags_d = flags_q;
    if (done) begin
      if (is_clear || close) begin
        ncnt_d  = '0;
        vcnt_d  = '0;
        flags_d = '1;
      end else if (!is_read) begin
        ncnt_d  = ncnt_new;
        vcnt_d  = vcnt_new;
        flags_d = flags_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ncnt_q      <= '0;
      vcnt_q      <= '0;
      flags_q     <= '1;
    end else begin
      ncnt_q  <= ncnt_d;
      vcnt_q  <= vcnt_d;
      flags_q <= flags_d;
      if (fire) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      req_q <= req_i.payload;
    end
    if (done) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = rsp_q;

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= hdt_pkg::OCC_W'(hdt_pkg::ENTRIES))
    else $error("occupancy above table size");

  a_accept_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> busy_q)
    else $error("accepted word not in progress");

  a_done_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_q)
    else $error("finished word produced no response");

  a_found_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rsp_q.status == hdt_pkg::ST_FOUND) |->
      (rsp_q.found_index >= 7'(hdt_pkg::INDEX_BASE)))
    else $error("found index below base");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.insert && occ < hdt_pkg::OCC_W'(hdt_pkg::ENTRIES)) |=> occ == $past(occ) + 1'b1)
    else $error("insert did not add an entry");
`endif

endmodule
`default_nettype wire

@@ tb/hdt_checker.sv @@
// Checker for the header dynamic table: predicts each response word and compares it.
module hdt_checker
  import hdt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  hdt_req_if   req_mon,
  hdt_rsp_if   rsp_mon,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] name_mem  [ENTRIES][NAME_BYTES];
  logic [7:0] value_mem [ENTRIES][VALUE_BYTES];
  int         entry_nlen [ENTRIES];
  int         entry_vlen [ENTRIES];
  int         occupied;
  logic [7:0] open_bytes [NAME_BYTES + VALUE_BYTES];
  int         open_names;
  int         open_values;
  rsp_t       expected_q [$];

  function automatic bit open_fits();
    return open_names >= 1 && open_names <= NAME_BYTES && open_values <= VALUE_BYTES;
  endfunction

  function automatic void append_byte(logic part, logic [7:0] b);
    if (!part) begin
      if (open_names < NAME_BYTES) open_bytes[open_names] = b;
      if (open_names <= NAME_BYTES) open_names++;
    end else begin
      if (open_values < VALUE_BYTES) open_bytes[NAME_BYTES + open_values] = b;
      if (open_values <= VALUE_BYTES) open_values++;
    end
  endfunction

  function automatic void push_entry();
    int top;
    top = (occupied >= ENTRIES) ? ENTRIES - 1 : occupied;
    for (int s = top; s > 0; s--) begin
      name_mem[s]   = name_mem[s-1];
      value_mem[s]  = value_mem[s-1];
      entry_nlen[s] = entry_nlen[s-1];
      entry_vlen[s] = entry_vlen[s-1];
    end
    if (occupied < ENTRIES) occupied++;
    for (int k = 0; k < open_names; k++) name_mem[0][k] = open_bytes[k];
    for (int k = 0; k < open_values; k++) value_mem[0][k] = open_bytes[NAME_BYTES + k];
    entry_nlen[0] = open_names;
    entry_vlen[0] = open_values;
  endfunction

  // Slot of the newest exact match, or ENTRIES when nothing matches.
  function automatic int newest_match();
    bit same;
    if (!open_fits()) return ENTRIES;
    for (int s = 0; s < occupied; s++) begin
      same = (entry_nlen[s] == open_names) && (entry_vlen[s] == open_values);
      for (int k = 0; same && k < open_names; k++)
        if (name_mem[s][k] != open_bytes[k]) same = 0;
      for (int k = 0; same && k < open_values; k++)
        if (value_mem[s][k] != open_bytes[NAME_BYTES + k]) same = 0;
      if (same) return s;
    end
    return ENTRIES;
  endfunction

  function automatic rsp_t table_response(req_t w);
    rsp_t r;
    int   slot;
    r = '0;
    r.status = ST_ABSORBED;
    case (w.req_type)
      REQ_CLEAR: begin
        occupied    = 0;
        open_names  = 0;
        open_values = 0;
        r.status    = ST_CLEARED;
      end
      REQ_READ: begin
        slot = int'(w.entry_index) - INDEX_BASE;
        if (slot >= 0 && slot < occupied) begin
          r.name_length  = 6'(entry_nlen[slot]);
          r.value_length = 8'(entry_vlen[slot]);
          if (!w.part && w.byte_offset < entry_nlen[slot])
            r.read_byte = name_mem[slot][w.byte_offset];
          if (w.part && w.byte_offset < entry_vlen[slot])
            r.read_byte = value_mem[slot][w.byte_offset];
          r.status = ST_READ_OK;
        end else begin
          r.status = ST_BAD_IDX;
        end
      end
      default: begin
        if (w.has_byte) append_byte(w.part, w.data_byte);
        if (w.last) begin
          if (w.req_type == REQ_INSERT) begin
            if (open_fits()) begin
              push_entry();
              r.status = ST_INSERTED;
            end else begin
              r.status = ST_REJECTED;
            end
          end else begin
            slot = newest_match();
            if (slot < ENTRIES) begin
              r.status      = ST_FOUND;
              r.found_index = 7'(INDEX_BASE + slot);
            end else begin
              r.status = ST_MISS;
            end
          end
          open_names  = 0;
          open_values = 0;
        end
      end
    endcase
    r.entry_count = 5'(occupied);
    return r;
  endfunction

  task automatic compare_word(rsp_t got);
    rsp_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: response word with none expected: %p", $time, got);
      errors_o++;
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %s actual %0d", $time, want.status.name(), got.status);
      errors_o++;
    end
    if (got.found_index !== want.found_index) begin
      $display("%0t: found_index expected %0d actual %0d", $time, want.found_index,
               got.found_index);
      errors_o++;
    end
    if (got.read_byte !== want.read_byte) begin
      $display("%0t: read_byte expected %0h actual %0h", $time, want.read_byte,
               got.read_byte);
      errors_o++;
    end
    if (got.name_length !== want.name_length) begin
      $display("%0t: name_length expected %0d actual %0d", $time, want.name_length,
               got.name_length);
      errors_o++;
    end
    if (got.value_length !== want.value_length) begin
      $display("%0t: value_length expected %0d actual %0d", $time, want.value_length,
               got.value_length);
      errors_o++;
    end
    if (got.entry_count !== want.entry_count) begin
      $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
               got.entry_count);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occupied    = 0;
      open_names  = 0;
      open_values = 0;
      expected_q.delete();
      errors_o    = 0;
      pending_o   = 0;
    end else begin
      if (req_mon.valid && req_mon.ready) expected_q.push_back(table_response(req_mon.payload));
      if (rsp_mon.valid && rsp_mon.ready) compare_word(rsp_mon.payload);
      pending_o = expected_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// Top of the header dynamic table testbench: clock, reset, stimulus and verdict.
module testbench;
  import hdt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_TARGET = 600;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors;
  int   pending;
  int   words_sent = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 0;
  int   quiet_cycles = 0;
  int   pool_key [$];
  int   pool_nl [$];
  int   pool_vl [$];

  hdt_req_if req_ch ();
  hdt_rsp_if rsp_ch ();

  header_dynamic_table_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  hdt_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_mon   (req_ch),
    .rsp_mon   (rsp_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #6 clk_i = ~clk_i;

  // Each content key spells a fixed name and value, so finds can repeat an insert.
  function automatic logic [7:0] content_byte(int key, logic part, int pos);
    return part ? 8'((key * 53 + pos * 7 + 128)) : 8'((key * 37 + pos * 11));
  endfunction

  task automatic send_word(req_t w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid   = 1'b1;
    req_ch.payload = w;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    words_sent++;
  endtask

  function automatic req_t noise_word();
    req_t w;
    w = req_t'($urandom);
    w.entry_index = 7'($urandom);
    return w;
  endfunction

  // Sends one insert or find stream; a bad_pos at or above zero corrupts one name byte.
  task automatic send_stream(req_type_e kind, int key, int nl, int vl, bit mixed,
                             int bad_pos);
    req_t w;
    int   ni;
    int   vi;
    bit   split_close;
    ni = 0;
    vi = 0;
    split_close = (nl + vl == 0) || ($urandom_range(3) == 0);
    while (ni < nl || vi < vl) begin
      w = noise_word();
      w.has_byte = 1'b1;
      if (vi < vl && (ni >= nl || (mixed && $urandom_range(1)))) begin
        w.part      = 1'b1;
        w.data_byte = content_byte(key, 1'b1, vi);
        vi++;
      end else begin
        w.part      = 1'b0;
        w.data_byte = content_byte(key, 1'b0, ni) ^ ((ni == bad_pos) ? 8'h5a : 8'h00);
        ni++;
      end
      w.last = (ni == nl && vi == vl && !split_close);
      // Only the closing word decides the kind of the stream.
      w.req_type = (w.last || !mixed) ? kind : ($urandom_range(1) ? REQ_INSERT : REQ_FIND);
      send_word(w);
    end
    if (split_close) begin
      w = noise_word();
      w.req_type = kind;
      w.has_byte = 1'b0;
      w.last     = 1'b1;
      send_word(w);
    end
  endtask

  task automatic send_read(int index, logic part, int offset);
    req_t w;
    w = noise_word();
    w.req_type    = REQ_READ;
    w.entry_index = 7'(index);
    w.part        = part;
    w.byte_offset = 7'(offset);
    send_word(w);
  endtask

  task automatic send_clear();
    req_t w;
    w = noise_word();
    w.req_type = REQ_CLEAR;
    send_word(w);
  endtask

  task automatic random_stream(req_type_e kind);
    int key;
    int nl;
    int vl;
    int pick;
    int bad;
    nl  = $urandom_range(1, 4);
    vl  = $urandom_range(0, 5);
    key = $urandom_range(0, 4095);
    bad = -1;
    if (kind == REQ_FIND && pool_key.size() > 0 && $urandom_range(9) < 7) begin
      pick = $urandom_range(pool_key.size() - 1);
      key  = pool_key[pick];
      nl   = pool_nl[pick];
      vl   = pool_vl[pick];
      if ($urandom_range(5) == 0) bad = $urandom_range(nl - 1);
    end
    case ($urandom_range(49))
      0: nl = 0;
      1: nl = $urandom_range(NAME_BYTES - 1, NAME_BYTES + 2);
      2: vl = $urandom_range(VALUE_BYTES - 1, VALUE_BYTES + 2);
      default: ;
    endcase
    if (kind == REQ_INSERT) begin
      pool_key.push_back(key);
      pool_nl.push_back(nl);
      pool_vl.push_back(vl);
      if (pool_key.size() > 24) begin
        void'(pool_key.pop_front());
        void'(pool_nl.pop_front());
        void'(pool_vl.pop_front());
      end
    end
    send_stream(kind, key, nl, vl, $urandom_range(3) == 0, bad);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        rsp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off = 0;
      end
      rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int  choice;
    bit  held;
    bit  drained;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    held    = 0;
    drained = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part: empty table, minimal entries, reads at the edges, clear.
    send_clear();
    send_read(INDEX_BASE, 1'b0, 0);
    send_read(0, 1'b1, 127);
    send_read(127, 1'b0, 0);
    send_stream(REQ_INSERT, 7, 1, 0, 0, -1);
    send_stream(REQ_INSERT, 9, 0, 0, 0, -1);
    send_stream(REQ_FIND, 7, 1, 0, 0, -1);
    send_stream(REQ_FIND, 8, 1, 0, 0, -1);
    send_stream(REQ_INSERT, 11, 2, 3, 1, -1);
    send_stream(REQ_FIND, 11, 2, 3, 0, -1);
    send_stream(REQ_FIND, 7, 1, 0, 0, -1);
    send_read(INDEX_BASE, 1'b1, 2);
    send_read(INDEX_BASE + 1, 1'b0, 0);
    send_read(INDEX_BASE + 1, 1'b0, 127);
    send_read(INDEX_BASE + 2, 1'b0, 0);
    send_clear();
    send_stream(REQ_FIND, 7, 1, 0, 0, -1);

    while (words_sent < WORD_TARGET) begin
      case ((words_sent / 75) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (!held && words_sent >= 250) begin
        held = 1;
        send_idle_pct = 0;
        hold_off = 1;
      end
      if (!drained && words_sent >= 420) begin
        drained = 1;
        wait (pending == 0);
        @(negedge clk_i);
      end
      choice = $urandom_range(99);
      if (choice < 45)      random_stream(REQ_INSERT);
      else if (choice < 72) random_stream(REQ_FIND);
      else if (choice < 90)
        send_read($urandom_range(3) == 0 ? $urandom_range(127) : $urandom_range(60, 79),
                  1'($urandom), $urandom_range(3) == 0 ? $urandom_range(127)
                                                        : $urandom_range(8));
      else if (choice < 92) send_clear();
      else                  send_word(noise_word());
    end

    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
